@@ sv/frame_tick_time_converter_macros.svh @@
// Assertion macros for the frame tick / timestamp converter.
// Included by every RTL file that carries concurrent assertions; depends on nothing.
// Define ASSERT_OFF to compile all assertions away.
`ifndef FRAME_TICK_TIME_CONVERTER_MACROS_SVH
`define FRAME_TICK_TIME_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define FTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftc assertion failed");

`else

`define FTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FTC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/ftc_pkg.sv @@
// Shared widths, codes, reset values and struct types of the frame tick converter.
// No dependencies; compiled before every other file of the block.
package ftc_pkg;

    // Field widths
    localparam int VAL_W  = 64;
    localparam int NUM_W  = 20;
    localparam int DEN_W  = 12;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 2;

    // K = rate_den * 1e9 stays below 2^42
    localparam int K_W    = 42;
    // magnitude times K stays below 2^106
    localparam int PROD_W = VAL_W + K_W;
    // signed working width of times and differences
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = SUM_W - VAL_W;

    // Counter widths of the shared unit
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int BIT_W  = $clog2(K_W);

    localparam logic [K_W-1:0] NS_PER_SEC = K_W'(64'd1000000000);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK2TIME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIME2TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DURATION  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RATE_NUM  = 2'd0;
    localparam logic [IDX_W-1:0] REG_RATE_DEN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN    = 2'd2;

    // Reset values
    localparam logic [NUM_W-1:0] RATE_NUM_RST  = 20'd30000;
    localparam logic [DEN_W-1:0] RATE_DEN_RST  = 12'd1001;
    localparam logic [K_W-1:0]   K_RST         = K_W'(64'd1001000000000);
    localparam logic [VAL_W-1:0] ORIGIN_RST    = '0;

    // Saturation bounds
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [NUM_W-1:0]        rate_num;
        logic [DEN_W-1:0]        rate_den;
        logic [K_W-1:0]          k;
        logic signed [VAL_W-1:0] origin_ns;
    } t_cfg;

    // Request to the shared multiply/divide unit: quot = (a * b[nbits-1:0]) / d
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [K_W-1:0]   b;
        logic [BIT_W-1:0] nbits;
        logic [K_W-1:0]   d;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
        logic [K_W-1:0]    rem;
    } t_md_rsp;

endpackage

@@ sv/ftc_interfaces.sv @@
// Valid/ready channel interfaces of the frame tick converter: config, input, result.
// Depends on ftc_pkg for the field widths.
interface ftc_cfg_if;
    import ftc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ftc_in_if;
    import ftc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ftc_out_if;
    import ftc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result;
    logic                    range_error;
    modport source (output valid, output result, output range_error, input ready);
    modport sink   (input valid, input result, input range_error, output ready);
endinterface

@@ sv/ftc_cfg.sv @@
// Configuration register file: rate numerator, denominator and origin, plus K = den * 1e9.
// Depends on ftc_pkg and the ftc_cfg_if interface.
module ftc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ftc_cfg_if.sink       i_cfg,
    output ftc_pkg::t_cfg o_cfg
);
    import ftc_pkg::*;

    logic [NUM_W-1:0] r_rate_num;
    logic [DEN_W-1:0] r_rate_den;
    logic [K_W-1:0]   r_k;
    logic [VAL_W-1:0] r_origin;
    logic [K_W-1:0]   n_k;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    // K follows the written denominator in the same transfer (12 x 30 bit product)
    assign n_k = K_W'(i_cfg.data[DEN_W-1:0]) * NS_PER_SEC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num <= RATE_NUM_RST;
            r_rate_den <= RATE_DEN_RST;
            r_k        <= K_RST;
            r_origin   <= ORIGIN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RATE_NUM: begin
                    r_rate_num <= i_cfg.data[NUM_W-1:0];
                end
                REG_RATE_DEN: begin
                    r_rate_den <= i_cfg.data[DEN_W-1:0];
                    r_k        <= n_k;
                end
                REG_ORIGIN: begin
                    r_origin   <= i_cfg.data;
                end
                default: begin
                    // index outside the register list: ignored
                end
            endcase
        end
    end

    assign o_cfg.rate_num  = r_rate_num;
    assign o_cfg.rate_den  = r_rate_den;
    assign o_cfg.k         = r_k;
    assign o_cfg.origin_ns = r_origin;

endmodule

@@ sv/ftc_muldiv.sv @@
// Shared serial unit: shift-add multiply, one multiplier bit per cycle, then
// restoring divide, one quotient bit per cycle. Depends on ftc_pkg and the macros header.
`include "frame_tick_time_converter_macros.svh"

module ftc_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ftc_pkg::t_md_req i_req,
    output ftc_pkg::t_md_rsp o_rsp
);
    import ftc_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_md_state;

    t_md_state         r_state;
    logic [VAL_W-1:0]  r_a;
    logic [K_W-1:0]    r_b;
    logic [K_W-1:0]    r_d;
    logic [BIT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_dq;
    logic [K_W-1:0]    r_rem;
    logic              r_done;

    logic [PROD_W-1:0] mac_sum;
    logic [K_W:0]      rem_shift;
    logic [K_W+1:0]    rem_diff;
    logic              q_bit;

    // MSB-first multiply step: acc = 2*acc + bit * a
    assign mac_sum = {r_dq[PROD_W-2:0], 1'b0} + (r_b[r_idx] ? PROD_W'(r_a) : '0);

    // Restoring divide step: bring in the next dividend bit, try to subtract
    assign rem_shift = {r_rem, r_dq[PROD_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, r_d};
    assign q_bit     = ~rem_diff[K_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_d     <= i_req.d;
                        r_idx   <= i_req.nbits - 1'b1;
                        r_dq    <= '0;
                        r_rem   <= '0;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_done <= 1'b0;
                    r_dq   <= mac_sum;
                    if (r_idx == '0) begin
                        r_cnt   <= CNT_W'(PROD_W - 1);
                        r_state <= U_DIV;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                U_DIV: begin
                    r_dq  <= {r_dq[PROD_W-2:0], q_bit};
                    r_rem <= q_bit ? rem_diff[K_W-1:0] : rem_shift[K_W-1:0];
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_done <= 1'b0;
                        r_cnt  <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;
    assign o_rsp.rem  = r_rem;

    // Sequencer only starts an idle unit
    `FTC_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == U_IDLE)
    // Partial remainder always stays below the divisor
    `FTC_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == U_DIV, r_rem < r_d)
    // Multiplier bit select stays inside the operand
    `FTC_ASSERT_IMP(a_bit_in_range, i_clk, i_rst_n, r_state == U_MUL, r_idx < BIT_W'(K_W))

endmodule

@@ sv/frame_tick_time_converter.sv @@
// Frame tick / timestamp converter for a rational frame rate rate_num/rate_den with tick
// zero at origin_ns. Command 0 returns the time of a tick, command 1 the tick that covers
// a timestamp, command 2 the frame duration rounded to nearest; overflow of command 0
// saturates and sets range_error, a zero rate register gives 0 with range_error. One item
// is in work at a time; the input is ready again as soon as the result sits in the output
// register. Command 1 spends at least two tick-time evaluations settling its estimate,
// plus one per correction step; command 3 and a zero rate go straight to the done state.
// The shared serial unit's shift-add multiplier takes one multiplier bit per cycle (42
// bits of K, or 20 bits of rate_num) and its restoring divider one of 106 quotient bits
// per cycle. A result held in the output register by a stalled sink holds the sequencer
// until it leaves. Configuration writes are taken in every cycle.
//
// Top level: command sequencer with its shared 108-bit adder and the output register.
// Depends on ftc_pkg, ftc_interfaces, ftc_cfg, ftc_muldiv and the macros header.
`include "frame_tick_time_converter_macros.svh"

module frame_tick_time_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ftc_cfg_if.sink   i_cfg,
    ftc_in_if.sink    i_item,
    ftc_out_if.source o_result
);
    import ftc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_PREP   = 11'b00000000010,
        S_ABS    = 11'b00000000100,
        S_EST    = 11'b00000001000,
        S_NEXT   = 11'b00000010000,
        S_TT_NEG = 11'b00000100000,
        S_WAIT   = 11'b00001000000,
        S_TT_ADD = 11'b00010000000,
        S_CMP    = 11'b00100000000,
        S_DEC    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_cfg    cfg;
    t_md_req md_req;
    t_md_rsp md_rsp;

    t_state           r_state;
    logic [CMD_W-1:0] r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_n;
    logic [VAL_W-1:0] r_est;
    logic [SUM_W-1:0] r_t;
    logic             r_neg;
    logic             r_up;
    logic             r_tt;
    logic [VAL_W-1:0] r_res;
    logic             r_err;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_result;
    logic             r_out_err;

    logic [SUM_W-1:0] add_a;
    logic [SUM_W-1:0] add_b;
    logic             add_cin;
    logic [SUM_W-1:0] add_sum;
    logic [SUM_W-1:0] val_ext;
    logic [SUM_W-1:0] org_ext;
    logic [SUM_W-1:0] quot_ext;
    logic [SUM_W-1:0] qlo_ext;
    logic [SUM_W-1:0] n_ext;
    logic             fits;
    logic             zero_rate;
    logic             rate_fault;
    logic             item_xfer;
    logic             out_free;

    ftc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ftc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // Operand extensions
    assign val_ext  = {{EXT_W{r_val[VAL_W-1]}}, r_val};
    assign org_ext  = {{EXT_W{cfg.origin_ns[VAL_W-1]}}, cfg.origin_ns};
    assign quot_ext = SUM_W'(md_rsp.quot);
    assign qlo_ext  = SUM_W'(md_rsp.quot[VAL_W-1:0]);
    assign n_ext    = SUM_W'(r_n);

    // Zero rate register and handshake terms
    assign zero_rate  = (cfg.rate_num == '0) || (cfg.rate_den == '0);
    assign rate_fault = (i_item.cmd != CMD_NONE) && zero_rate;
    assign item_xfer  = i_item.valid && i_item.ready;
    assign out_free   = !r_out_valid || o_result.ready;

    // Shared adder
    assign add_sum = add_a + add_b + SUM_W'(add_cin);

    // Saturation check of a tick time
    assign fits = (&add_sum[SUM_W-1:VAL_W-1]) | ~(|add_sum[SUM_W-1:VAL_W-1]);

    // Adder operands and unit requests per step
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        md_req  = '0;
        unique case (r_state)
            S_PREP: begin
                if (r_cmd == CMD_DURATION) begin
                    // (K + num/2) / num
                    add_a        = SUM_W'(cfg.k);
                    add_b        = SUM_W'(cfg.rate_num >> 1);
                    md_req.start = 1'b1;
                    md_req.a     = add_sum[VAL_W-1:0];
                    md_req.b     = K_W'(1);
                    md_req.nbits = BIT_W'(1);
                    md_req.d     = K_W'(cfg.rate_num);
                end else begin
                    // timestamp minus origin
                    add_a   = val_ext;
                    add_b   = ~org_ext;
                    add_cin = 1'b1;
                end
            end
            S_ABS: begin
                // |diff| * num / K
                add_b        = r_t[SUM_W-1] ? ~r_t : r_t;
                add_cin      = r_t[SUM_W-1];
                md_req.start = 1'b1;
                md_req.a     = add_sum[VAL_W-1:0];
                md_req.b     = K_W'(cfg.rate_num);
                md_req.nbits = BIT_W'(NUM_W);
                md_req.d     = cfg.k;
            end
            S_EST: begin
                // negative side rounds toward minus infinity
                add_b   = r_neg ? ~qlo_ext : qlo_ext;
                add_cin = r_neg && (md_rsp.rem == '0);
            end
            S_NEXT: begin
                add_a   = SUM_W'(r_est);
                add_cin = r_up;
            end
            S_TT_NEG: begin
                // |n| * K / num
                add_b        = r_n[VAL_W-1] ? ~n_ext : n_ext;
                add_cin      = r_n[VAL_W-1];
                md_req.start = 1'b1;
                md_req.a     = add_sum[VAL_W-1:0];
                md_req.b     = cfg.k;
                md_req.nbits = BIT_W'(K_W);
                md_req.d     = K_W'(cfg.rate_num);
            end
            S_TT_ADD: begin
                add_a   = org_ext;
                add_b   = r_neg ? ~quot_ext : quot_ext;
                add_cin = r_neg;
            end
            S_CMP: begin
                // sign of target minus tick time
                add_a   = val_ext;
                add_b   = ~r_t;
                add_cin = 1'b1;
            end
            S_DEC: begin
                add_a = SUM_W'(r_est);
                add_b = '1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // output transfer empties the register unless a new result loads it
            if (r_out_valid && o_result.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_cmd <= i_item.cmd;
                        r_val <= i_item.value;
                        r_n   <= i_item.value;
                        r_res <= '0;
                        r_err <= rate_fault;
                        r_tt  <= 1'b0;
                        priority if (i_item.cmd == CMD_NONE) begin
                            r_state <= S_DONE;
                        end else if (zero_rate) begin
                            r_state <= S_DONE;
                        end else if (i_item.cmd == CMD_TICK2TIME) begin
                            r_state <= S_TT_NEG;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    if (r_cmd == CMD_DURATION) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_t     <= add_sum;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_t[SUM_W-1];
                    r_tt    <= 1'b0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (md_rsp.done) begin
                        priority if (r_cmd == CMD_DURATION) begin
                            r_res   <= md_rsp.quot[VAL_W-1:0];
                            r_state <= S_DONE;
                        end else if (r_tt) begin
                            r_state <= S_TT_ADD;
                        end else begin
                            r_state <= S_EST;
                        end
                    end
                end
                S_EST: begin
                    r_est   <= add_sum[VAL_W-1:0];
                    r_up    <= 1'b1;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    // tick to test: est + 1 while stepping up, est while stepping down
                    r_n     <= add_sum[VAL_W-1:0];
                    r_state <= S_TT_NEG;
                end
                S_TT_NEG: begin
                    r_neg   <= r_n[VAL_W-1];
                    r_tt    <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_TT_ADD: begin
                    if (r_cmd == CMD_TICK2TIME) begin
                        if (fits) begin
                            r_res <= add_sum[VAL_W-1:0];
                        end else begin
                            r_err <= 1'b1;
                            r_res <= add_sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_t     <= add_sum;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_up) begin
                        // next tick not later than target: take it
                        if (!add_sum[SUM_W-1]) begin
                            r_est <= r_n;
                        end else begin
                            r_up <= 1'b0;
                        end
                        r_state <= S_NEXT;
                    end else if (add_sum[SUM_W-1]) begin
                        r_state <= S_DEC;
                    end else begin
                        r_res   <= r_est;
                        r_state <= S_DONE;
                    end
                end
                S_DEC: begin
                    r_est   <= add_sum[VAL_W-1:0];
                    r_state <= S_NEXT;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_result <= r_res;
                        r_out_err    <= r_err;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.result      = r_out_result;
    assign o_result.range_error = r_out_err;

    // A zero rate register answers at once with range_error
    `FTC_ASSERT_NXT(a_zero_rate, i_clk, i_rst_n, item_xfer && rate_fault, r_state == S_DONE && r_err)
    // Only time to tick settles against the target
    `FTC_ASSERT_IMP(a_cmp_t2t, i_clk, i_rst_n, r_state == S_CMP, r_cmd == CMD_TIME2TICK)
    // A finished result enters the output register once it is free
    `FTC_ASSERT_NXT(a_out_load, i_clk, i_rst_n, r_state == S_DONE && out_free, r_out_valid && i_item.ready)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of frame_tick_time_converter: directed and random conversions
// checked against a built-in exact predictor. Depends on ftc_pkg, ftc_interfaces and the RTL.
`timescale 1ns / 1ps

module testbench;
    import ftc_pkg::*;

    // Register index that the block ignores
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [NUM_W-1:0] NUM_MAX    = {NUM_W{1'b1}};
    localparam logic [DEN_W-1:0] DEN_MAX    = {DEN_W{1'b1}};
    localparam logic signed [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic signed [129:0] wide_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result;
        logic                    range_error;
    } conv_result_t;

    logic i_clk;
    logic i_rst_n;

    ftc_cfg_if cfg_bus ();
    ftc_in_if  item_bus ();
    ftc_out_if result_bus ();

    frame_tick_time_converter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    // Register copy of the predictor
    logic [NUM_W-1:0]        model_rate_num;
    logic [DEN_W-1:0]        model_rate_den;
    logic signed [VAL_W-1:0] model_origin;

    conv_result_t expected_results[$];
    int           mismatch_count = 0;
    logic         no_idle;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Overall time limit
    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact time of a tick: origin + trunc(tick * K / rate_num)
    function automatic wide_t frame_time(logic signed [VAL_W-1:0] tick);
        wide_t n, k, d, org;
        n   = tick;
        k   = model_rate_den;
        k   = k * 1000000000;
        d   = model_rate_num;
        org = model_origin;
        return org + (n * k) / d;
    endfunction

    // Tick covering a timestamp: floor estimate, then settle against frame_time
    function automatic logic signed [VAL_W-1:0] tick_at_time(logic signed [VAL_W-1:0] stamp);
        wide_t target, org, num, k, prod, est_w;
        logic signed [VAL_W-1:0] est;
        target = stamp;
        org    = model_origin;
        num    = model_rate_num;
        k      = model_rate_den;
        k      = k * 1000000000;
        prod   = (target - org) * num;
        est_w  = prod / k;
        if (prod < 0 && (prod % k) != 0)
            est_w = est_w - 1;
        est = est_w[VAL_W-1:0];
        while (frame_time(est + 64'sd1) <= target)
            est = est + 64'sd1;
        while (frame_time(est) > target)
            est = est - 64'sd1;
        return est;
    endfunction

    function automatic conv_result_t predict_conversion(logic [CMD_W-1:0] cmd,
                                                        logic signed [VAL_W-1:0] value);
        conv_result_t r;
        wide_t t, k, num, max_v, min_v;
        r.result      = '0;
        r.range_error = 1'b0;
        if (cmd == CMD_NONE)
            return r;
        // zero rate register: no conversion possible
        if (model_rate_num == '0 || model_rate_den == '0) begin
            r.range_error = 1'b1;
            return r;
        end
        case (cmd)
            CMD_TICK2TIME: begin
                t     = frame_time(value);
                max_v = VALUE_MAX;
                min_v = -max_v - 1;
                if (t > max_v) begin
                    r.result      = VALUE_MAX;
                    r.range_error = 1'b1;
                end else if (t < min_v) begin
                    r.result      = VALUE_MIN;
                    r.range_error = 1'b1;
                end else begin
                    r.result = t[VAL_W-1:0];
                end
            end
            CMD_TIME2TICK: r.result = tick_at_time(value);
            default: begin
                // frame duration, rounded to nearest
                num      = model_rate_num;
                k        = model_rate_den;
                k        = k * 1000000000;
                t        = (k + num / 2) / num;
                r.result = t[VAL_W-1:0];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------

    always @(posedge i_clk)
        result_bus.ready <= no_idle || ($urandom_range(99) >= 16);

    always @(posedge i_clk) begin : check_results
        conv_result_t want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending: result %0d range_error %0b",
                       result_bus.result, result_bus.range_error);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (result_bus.result !== want.result) begin
                    $error("mismatch on result: expected %0d, actual %0d",
                           want.result, result_bus.result);
                    mismatch_count++;
                end
                if (result_bus.range_error !== want.range_error) begin
                    $error("mismatch on range_error: expected %0b, actual %0b",
                           want.range_error, result_bus.range_error);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic logic [VAL_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // One conversion request; leaves valid high after the transfer
    task automatic send_conversion(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] value);
        while (!no_idle && $urandom_range(99) < 16) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.cmd   <= cmd;
        item_bus.value <= value;
        do @(posedge i_clk); while (!item_bus.ready);
        expected_results.push_back(predict_conversion(cmd, value));
    endtask

    // One register write; leaves valid high after the transfer
    task automatic write_register(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] data);
        while (!no_idle && $urandom_range(99) < 16) begin
            cfg_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_RATE_NUM: model_rate_num = data[NUM_W-1:0];
            REG_RATE_DEN: model_rate_den = data[DEN_W-1:0];
            REG_ORIGIN:   model_origin   = data;
            default: ;    // ignored by the block
        endcase
    endtask

    // Stop sending and wait until every pending result has been taken
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Idle the block, then load all three registers; upper bits of the rate writes are junk
    task automatic set_rate(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den,
                            logic signed [VAL_W-1:0] origin);
        logic [VAL_W-1:0] data;
        drain_results();
        data            = random_word();
        data[NUM_W-1:0] = num;
        write_register(REG_RATE_NUM, data);
        data            = random_word();
        data[DEN_W-1:0] = den;
        write_register(REG_RATE_DEN, data);
        write_register(REG_ORIGIN, origin);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random request, weighted toward timestamps close to frame boundaries
    task automatic send_random_item();
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic signed [31:0]      short_word;
        logic [VAL_W-1:0]        w;
        wide_t                   t;
        int                      sel;
        sel = $urandom_range(99);
        cmd = (sel < 40) ? CMD_TICK2TIME : (sel < 85) ? CMD_TIME2TICK :
              (sel < 95) ? CMD_DURATION : CMD_NONE;
        sel = $urandom_range(99);
        w   = random_word();
        if (cmd == CMD_TICK2TIME) begin
            if (sel < 50) begin
                value = $urandom_range(200000);
                value = value - 64'sd100000;
            end else if (sel < 75) begin
                value = w;
            end else if (sel < 85) begin
                value = w[0] ? VALUE_MAX - $urandom_range(3) : VALUE_MIN + $urandom_range(3);
            end else begin
                // ticks around where the time leaves 64 bits
                value = {{24{w[39]}}, w[39:0]};
            end
        end else if (cmd == CMD_TIME2TICK) begin
            if (sel < 50) begin
                value = {{40{w[23]}}, w[23:0]};
                t     = frame_time(value);
                value = t[VAL_W-1:0] + $urandom_range(4) - 64'sd2;
            end else if (sel < 80) begin
                value = w;
            end else begin
                short_word = $urandom;
                value      = model_origin + short_word;
            end
        end else begin
            value = w;
        end
        send_conversion(cmd, value);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command at the reset settings
    task automatic test_reset_values();
        send_conversion(CMD_TICK2TIME, 64'sd0);
        send_conversion(CMD_TICK2TIME, 64'sd1);
        send_conversion(CMD_TICK2TIME, -64'sd1);
        send_conversion(CMD_TIME2TICK, 64'sd0);
        send_conversion(CMD_TIME2TICK, 64'sd33366666);
        send_conversion(CMD_TIME2TICK, -64'sd1);
        send_conversion(CMD_DURATION, 64'sd0);
        send_conversion(CMD_NONE, -64'sd1);
    endtask

    // Extreme rates and origins: saturation both ways, time-to-tick at the bounds
    task automatic test_range_limits();
        set_rate(NUM_MAX, 12'd1, VALUE_MAX);
        send_conversion(CMD_TICK2TIME, VALUE_MAX);
        send_conversion(CMD_TICK2TIME, VALUE_MIN);
        send_conversion(CMD_TICK2TIME, 64'sd0);
        send_conversion(CMD_TIME2TICK, VALUE_MAX);
        send_conversion(CMD_TIME2TICK, VALUE_MIN);
        send_conversion(CMD_DURATION, 64'sd0);
        set_rate(20'd1, DEN_MAX, VALUE_MIN);
        send_conversion(CMD_TICK2TIME, 64'sd1);
        send_conversion(CMD_TICK2TIME, -64'sd1);
        send_conversion(CMD_TIME2TICK, VALUE_MAX);
        send_conversion(CMD_TIME2TICK, VALUE_MIN);
        send_conversion(CMD_DURATION, 64'sd0);
    endtask

    // Zero numerator, then zero denominator
    task automatic test_zero_rate();
        set_rate(20'd0, 12'd1001, 64'sd0);
        send_conversion(CMD_TICK2TIME, 64'sd5);
        send_conversion(CMD_TIME2TICK, 64'sd5);
        send_conversion(CMD_DURATION, 64'sd5);
        send_conversion(CMD_NONE, 64'sd5);
        set_rate(20'd30000, 12'd0, 64'sd0);
        send_conversion(CMD_TIME2TICK, 64'sd5);
    endtask

    // Write to the unused index must not disturb the registers
    task automatic test_unused_register();
        set_rate(20'd60000, 12'd1001, 64'sd0);
        @(posedge i_clk);
        write_register(REG_UNUSED, random_word());
        cfg_bus.valid <= 1'b0;
        send_conversion(CMD_DURATION, 64'sd0);
        send_conversion(CMD_TICK2TIME, 64'sd1000);
    endtask

    task automatic run_random_phase(int count, logic [NUM_W-1:0] num,
                                    logic [DEN_W-1:0] den, logic signed [VAL_W-1:0] origin);
        set_rate(num, den, origin);
        repeat (count) send_random_item();
    endtask

    // Random traffic over several settings; one phase runs with no idling
    task automatic test_random_traffic();
        logic [NUM_W-1:0]        num;
        logic [DEN_W-1:0]        den;
        logic signed [VAL_W-1:0] origin;
        logic signed [31:0]      short_word;
        run_random_phase(153, NUM_MAX, DEN_MAX, random_word());
        run_random_phase(153, 20'd1, 12'd1, random_word());
        for (int phase = 2; phase < 8; phase++) begin
            case ($urandom_range(5))
                0:       num = 20'd1;
                1:       num = NUM_MAX;
                2:       num = 20'd30000;
                3:       num = 20'd24000;
                4:       num = NUM_W'($urandom_range(1000, 1));
                default: num = NUM_W'($urandom_range(NUM_MAX, 1));
            endcase
            case ($urandom_range(5))
                0:       den = 12'd1;
                1:       den = DEN_MAX;
                2:       den = 12'd1001;
                3:       den = 12'd1000;
                default: den = DEN_W'($urandom_range(DEN_MAX, 1));
            endcase
            short_word = $urandom;
            case ($urandom_range(5))
                0:       origin = 64'sd0;
                1:       origin = VALUE_MAX;
                2:       origin = VALUE_MIN;
                3:       origin = short_word;
                default: origin = random_word();
            endcase
            if (phase == 3)
                no_idle <= 1'b1;
            run_random_phase(153, num, den, origin);
            if (phase == 3) begin
                drain_results();
                no_idle <= 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        model_rate_num   = RATE_NUM_RST;
        model_rate_den   = RATE_DEN_RST;
        model_origin     = ORIGIN_RST;
        no_idle          <= 1'b0;
        i_rst_n          <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_RATE_NUM;
        cfg_bus.data     <= '0;
        item_bus.valid   <= 1'b0;
        item_bus.cmd     <= CMD_NONE;
        item_bus.value   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_range_limits();
        test_zero_rate();
        test_unused_register();
        test_random_traffic();

        drain_results();
        repeat (1000) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
